// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define SSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ssm_pkg.sv =====
// types, codes and constants of the sorted set merge unit
`default_nettype none

package ssm_pkg;

    localparam int MAX_ELEMS_DEF = 32;
    localparam int DATA_W        = 32;

    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;

    localparam logic [1:0] MODE_AND = 2'd0;
    localparam logic [1:0] MODE_OR  = 2'd1;
    localparam logic [1:0] MODE_SUB = 2'd2;

    typedef struct packed {
        logic [1:0]               operation;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     last;
        logic                     empty_res;
        logic                     overflow;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_FINISH
    } ssm_state_t;

endpackage

`default_nettype wire

// ===== sv/sorted_set_merge_ops.sv =====
// top level of the sorted set merge unit
//
//   channel  | signals                    | beat
//   ---------+----------------------------+-------------------------------
//   in       | in_valid/in_ready/in_data  | load into a store, or run
//   out      | out_valid/out_ready/out_data| one element of the result
//   cfg      | cfg_we/cfg_data            | combine_mode write
//
// loads stream one beat per cycle while no run is in progress
// a run does each merge step as a store read, then a compare, and ends
// with a closing step that sends the last-marked beat
// a compare holds while it would emit and the pending element cannot leave
// asynchronous active-low reset clears counts, flags and the mode register
`default_nettype none

module sorted_set_merge_ops #(
    parameter int MAX_ELEMS = ssm_pkg::MAX_ELEMS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ssm_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ssm_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_data
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;

    logic                              wr_a_en, wr_b_en;
    logic [AW-1:0]                     wr_a_addr, wr_b_addr;
    logic signed [ssm_pkg::DATA_W-1:0] wr_data;
    logic [AW-1:0]                     rd_a_addr, rd_b_addr;
    logic signed [ssm_pkg::DATA_W-1:0] rd_a_data, rd_b_data;

    ssm_ctrl #(
        .MAX_ELEMS (MAX_ELEMS),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .wr_a_en   (wr_a_en),
        .wr_b_en   (wr_b_en),
        .wr_a_addr (wr_a_addr),
        .wr_b_addr (wr_b_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    ssm_mem #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW)
    ) u_first_set (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_a_addr),
        .wr_data (wr_data),
        .rd_addr (rd_a_addr),
        .rd_data (rd_a_data)
    );

    ssm_mem #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW)
    ) u_second_set (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_b_addr),
        .wr_data (wr_data),
        .rd_addr (rd_b_addr),
        .rd_data (rd_b_data)
    );

endmodule

`default_nettype wire

// ===== sv/ssm_mem.sv =====
// one element store: single write port, registered read port
`default_nettype none

module ssm_mem #(
    parameter int DEPTH = ssm_pkg::MAX_ELEMS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [AW-1:0]                    wr_addr,
    input  wire logic signed [ssm_pkg::DATA_W-1:0] wr_data,
    input  wire logic [AW-1:0]                    rd_addr,
    output logic signed [ssm_pkg::DATA_W-1:0]      rd_data
);

    logic signed [ssm_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== sv/ssm_ctrl.sv =====
// load, merge walk and result register of the sorted set merge unit
`default_nettype none

module ssm_ctrl #(
    parameter int MAX_ELEMS = ssm_pkg::MAX_ELEMS_DEF,
    parameter int AW        = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire ssm_pkg::in_item_t                 in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output ssm_pkg::out_item_t                     out_data,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_data,
    output logic                                   wr_a_en,
    output logic                                   wr_b_en,
    output logic [AW-1:0]                          wr_a_addr,
    output logic [AW-1:0]                          wr_b_addr,
    output logic signed [ssm_pkg::DATA_W-1:0]      wr_data,
    output logic [AW-1:0]                          rd_a_addr,
    output logic [AW-1:0]                          rd_b_addr,
    input  wire logic signed [ssm_pkg::DATA_W-1:0] rd_a_data,
    input  wire logic signed [ssm_pkg::DATA_W-1:0] rd_b_data
);

    localparam int CW = $clog2(MAX_ELEMS + 1);

    ssm_pkg::ssm_state_t state_reg, state_next;
    logic [CW-1:0]       cnt_a_reg, cnt_a_next;
    logic [CW-1:0]       cnt_b_reg, cnt_b_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                dropped_reg, dropped_next;
    logic [1:0]          mode_reg;
    logic                pend_valid_reg, pend_valid_next;
    logic signed [ssm_pkg::DATA_W-1:0] pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    ssm_pkg::out_item_t  out_reg, out_next;

    logic                a_done, b_done;
    logic                take_a, take_b, take_both;
    logic signed [ssm_pkg::DATA_W-1:0] sel_v;
    logic                emit;
    logic                out_free;
    logic [CW-1:0]       i_adv, j_adv;
    logic                push;
    ssm_pkg::out_item_t  push_item;

    assign wr_a_addr = cnt_a_reg[AW-1:0];
    assign wr_b_addr = cnt_b_reg[AW-1:0];
    assign wr_data   = in_data.value;
    assign rd_a_addr = i_reg[AW-1:0];
    assign rd_b_addr = j_reg[AW-1:0];
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // two-pointer step on the heads read last cycle
    always_comb
    begin
        a_done    = (i_reg == cnt_a_reg);
        b_done    = (j_reg == cnt_b_reg);
        take_a    = 1'b0;
        take_b    = 1'b0;
        take_both = 1'b0;
        sel_v     = rd_a_data;
        priority if (a_done)
        begin
            take_b = 1'b1;
            sel_v  = rd_b_data;
        end
        else if (b_done)
        begin
            take_a = 1'b1;
        end
        else if (rd_a_data < rd_b_data)
        begin
            take_a = 1'b1;
        end
        else if (rd_b_data < rd_a_data)
        begin
            take_b = 1'b1;
            sel_v  = rd_b_data;
        end
        else
        begin
            take_both = 1'b1;
        end
        unique case (mode_reg)
            ssm_pkg::MODE_AND: emit = take_both;
            ssm_pkg::MODE_OR:  emit = 1'b1;
            ssm_pkg::MODE_SUB: emit = take_a;
            default:           emit = 1'b0;
        endcase
        i_adv = i_reg + CW'(take_a || take_both);
        j_adv = j_reg + CW'(take_b || take_both);
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        dropped_next    = dropped_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        in_ready        = 1'b0;
        wr_a_en         = 1'b0;
        wr_b_en         = 1'b0;
        push            = 1'b0;
        push_item       = '{element: pend_reg, last: 1'b0, empty_res: 1'b0,
                            overflow: dropped_reg};
        unique case (state_reg)
            ssm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_data.operation)
                        ssm_pkg::OP_LOAD_FIRST:
                        begin
                            if (cnt_a_reg < CW'(MAX_ELEMS))
                            begin
                                wr_a_en    = 1'b1;
                                cnt_a_next = cnt_a_reg + CW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        ssm_pkg::OP_LOAD_SECOND:
                        begin
                            if (cnt_b_reg < CW'(MAX_ELEMS))
                            begin
                                wr_b_en    = 1'b1;
                                cnt_b_next = cnt_b_reg + CW'(1);
                            end
                            else
                            begin
                                dropped_next = 1'b1;
                            end
                        end
                        ssm_pkg::OP_RUN:
                        begin
                            if (cnt_a_reg == '0 && cnt_b_reg == '0)
                            begin
                                state_next = ssm_pkg::ST_FINISH;
                            end
                            else
                            begin
                                state_next = ssm_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ssm_pkg::ST_READ:
            begin
                state_next = ssm_pkg::ST_COMPARE;
            end
            ssm_pkg::ST_COMPARE:
            begin
                // hold while an older element still cannot leave
                if (!(emit && pend_valid_reg && !out_free))
                begin
                    i_next = i_adv;
                    j_next = j_adv;
                    if (emit)
                    begin
                        push            = pend_valid_reg;
                        pend_next       = sel_v;
                        pend_valid_next = 1'b1;
                    end
                    if (i_adv == cnt_a_reg && j_adv == cnt_b_reg)
                    begin
                        state_next = ssm_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = ssm_pkg::ST_READ;
                    end
                end
            end
            ssm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    push           = 1'b1;
                    push_item.last = 1'b1;
                    if (!pend_valid_reg)
                    begin
                        push_item.element   = '0;
                        push_item.empty_res = 1'b1;
                    end
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    i_next          = '0;
                    j_next          = '0;
                    dropped_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ssm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssm_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_next       = push ? push_item : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssm_pkg::ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            dropped_reg    <= 1'b0;
            mode_reg       <= ssm_pkg::MODE_AND;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

// ===== sv/ssm_checker.sv =====
// port-level checker for the sorted set merge unit, with its bind
`default_nettype none

`include "assert_macros.svh"

module ssm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire ssm_pkg::in_item_t  in_data,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire ssm_pkg::out_item_t out_data
);

    // a run beat closes the input until its last element is out
    `SSM_ASSERT_NXT(a_run_blocks_in, clk, rst_n, in_valid && in_ready && in_data.operation == ssm_pkg::OP_RUN, !in_ready, "input open right after a run beat")

    // an element that is not the last means the run is still going
    `SSM_ASSERT_IMP(a_mid_run_busy, clk, rst_n, out_valid && !out_data.last, !in_ready, "input open while a run is unfinished")

    `SSM_ASSERT_IMP(a_empty_is_last, clk, rst_n, out_valid && out_data.empty_res, out_data.last, "empty result without last mark")

    `SSM_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && out_data.empty_res, out_data.element == '0, "empty result carries an element")

    `SSM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result beat changed")

endmodule

bind sorted_set_merge_ops ssm_checker u_ssm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/sorted_set_merge_ops_test.sv =====
// self-checking testbench for the sorted set merge unit
`timescale 1ns / 100ps

module sorted_set_merge_ops_test;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int STORE_DEPTH  = ssm_pkg::MAX_ELEMS_DEF;
    localparam int DRAIN_CYCLES = 16;
    localparam int END_CYCLES   = 4 * STORE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    ssm_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    ssm_pkg::out_item_t out_data;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_data = ssm_pkg::MODE_AND;

    // predictor state
    logic signed [31:0] first_store [STORE_DEPTH];
    logic signed [31:0] second_store [STORE_DEPTH];
    int                 first_len = 0;
    int                 second_len = 0;
    bit                 dropped = 1'b0;
    logic [1:0]         merge_mode = ssm_pkg::MODE_AND;
    ssm_pkg::out_item_t result_q [$];

    int          fail_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;

    sorted_set_merge_ops u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** sorted_set_merge_ops: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 8);

    // result beat checker
    always @(posedge clk)
    begin
        ssm_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected result beat, element %0d", out_data.element);
                fail_count++;
            end
            else
            begin
                want = result_q.pop_front();
                if (out_data.element !== want.element)
                begin
                    $error("element: expected %0d, got %0d", want.element, out_data.element);
                    fail_count++;
                end
                if (out_data.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, out_data.last);
                    fail_count++;
                end
                if (out_data.empty_res !== want.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", want.empty_res,
                           out_data.empty_res);
                    fail_count++;
                end
                if (out_data.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
                    fail_count++;
                end
            end
        end
    end

    function automatic void predict_beat(ssm_pkg::in_item_t beat);
        int                 i;
        int                 j;
        int                 produced;
        logic signed [31:0] v;
        bit                 from_first;
        bit                 from_second;
        ssm_pkg::out_item_t r;
        i = 0;
        j = 0;
        produced = 0;
        case (beat.operation)
            ssm_pkg::OP_LOAD_FIRST:
                if (first_len < STORE_DEPTH)
                begin
                    first_store[first_len] = beat.value;
                    first_len++;
                end
                else
                    dropped = 1'b1;
            ssm_pkg::OP_LOAD_SECOND:
                if (second_len < STORE_DEPTH)
                begin
                    second_store[second_len] = beat.value;
                    second_len++;
                end
                else
                    dropped = 1'b1;
            ssm_pkg::OP_RUN:
            begin
                while (i < first_len || j < second_len)
                begin
                    from_first = 1'b0;
                    from_second = 1'b0;
                    if (i == first_len)
                    begin
                        v = second_store[j];
                        from_second = 1'b1;
                        j++;
                    end
                    else if (j == second_len)
                    begin
                        v = first_store[i];
                        from_first = 1'b1;
                        i++;
                    end
                    else if (first_store[i] < second_store[j])
                    begin
                        v = first_store[i];
                        from_first = 1'b1;
                        i++;
                    end
                    else if (second_store[j] < first_store[i])
                    begin
                        v = second_store[j];
                        from_second = 1'b1;
                        j++;
                    end
                    else
                    begin
                        v = first_store[i];
                        i++;
                        j++;
                    end
                    if ((merge_mode == ssm_pkg::MODE_OR) ||
                        (merge_mode == ssm_pkg::MODE_AND && !from_first && !from_second) ||
                        (merge_mode == ssm_pkg::MODE_SUB && from_first))
                    begin
                        r.element = v;
                        r.last = 1'b0;
                        r.empty_res = 1'b0;
                        r.overflow = dropped;
                        result_q = {result_q, r};
                        produced++;
                    end
                end
                if (produced == 0)
                begin
                    r.element = '0;
                    r.last = 1'b0;
                    r.empty_res = 1'b1;
                    r.overflow = dropped;
                    result_q = {result_q, r};
                end
                result_q[$].last = 1'b1;
                first_len = 0;
                second_len = 0;
                dropped = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [31:0] val);
        ssm_pkg::in_item_t beat;
        beat.operation = op;
        beat.value = val;
        if (!steady && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 30);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_beat(beat);
        if (op != OP_NONE)
            items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= mode;
        @(posedge clk);
        cfg_we <= 1'b0;
        merge_mode = mode;
    endtask

    task automatic test_empty_runs();
        set_mode(ssm_pkg::MODE_AND);
        send_beat(ssm_pkg::OP_RUN, $urandom);
        set_mode(ssm_pkg::MODE_OR);
        send_beat(ssm_pkg::OP_RUN, $urandom);
        set_mode(ssm_pkg::MODE_SUB);
        send_beat(ssm_pkg::OP_RUN, $urandom);
        set_mode(MODE_NONE);
        send_beat(ssm_pkg::OP_RUN, $urandom);
    endtask

    task automatic test_extreme_values();
        set_mode(ssm_pkg::MODE_OR);
        send_beat(ssm_pkg::OP_LOAD_FIRST, INT_MIN);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'hFFFF_FFFF);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd0);
        send_beat(ssm_pkg::OP_LOAD_FIRST, INT_MAX);
        send_beat(ssm_pkg::OP_LOAD_SECOND, INT_MIN);
        send_beat(ssm_pkg::OP_LOAD_SECOND, 32'd1);
        send_beat(ssm_pkg::OP_LOAD_SECOND, INT_MAX);
        send_beat(ssm_pkg::OP_RUN, 32'd0);
    endtask

    task automatic test_difference_and_ignored();
        set_mode(ssm_pkg::MODE_SUB);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd5);
        send_beat(OP_NONE, 32'hFFFF_FFFF);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd9);
        send_beat(ssm_pkg::OP_LOAD_SECOND, 32'd5);
        send_beat(ssm_pkg::OP_RUN, 32'hFFFF_FFFF);
        // disjoint lists give nothing in common
        set_mode(ssm_pkg::MODE_AND);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd3);
        send_beat(ssm_pkg::OP_LOAD_SECOND, 32'd4);
        send_beat(ssm_pkg::OP_RUN, 32'd0);
    endtask

    task automatic test_unsorted_lists();
        set_mode(ssm_pkg::MODE_OR);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd7);
        send_beat(ssm_pkg::OP_LOAD_FIRST, 32'd2);
        send_beat(ssm_pkg::OP_LOAD_SECOND, 32'd5);
        send_beat(ssm_pkg::OP_RUN, 32'd0);
    endtask

    task automatic test_store_full();
        set_mode(ssm_pkg::MODE_OR);
        for (int k = 0; k <= STORE_DEPTH; k++)
            send_beat(ssm_pkg::OP_LOAD_FIRST, 100 * k + $urandom_range(99) - 1600);
        send_beat(ssm_pkg::OP_LOAD_SECOND, 32'd50);
        send_beat(ssm_pkg::OP_RUN, $urandom);
        // flag must be clear on the following run
        send_beat(ssm_pkg::OP_RUN, $urandom);
    endtask

    task automatic test_random_merges();
        int                 base;
        int                 done;
        int                 first_goal;
        int                 second_goal;
        int                 pick;
        int                 step_max;
        bit                 jumbled;
        longint             v;
        logic signed [31:0] first_vals [$];
        logic signed [31:0] second_vals [$];
        base = items_sent;
        while (items_sent - base < 120)
        begin
            done = items_sent - base;
            steady = (done >= 40 && done < 90);
            if ($urandom_range(99) < 20)
                set_mode(($urandom_range(99) < 10) ? MODE_NONE : 2'($urandom_range(2)));
            pick = $urandom_range(99);
            first_goal = (pick < 60) ? $urandom_range(6) : (pick < 90) ? $urandom_range(16) :
                         (pick < 95) ? $urandom_range(32, 25) : $urandom_range(35, 33);
            pick = $urandom_range(99);
            second_goal = (pick < 60) ? $urandom_range(6) : (pick < 90) ? $urandom_range(16) :
                          (pick < 95) ? $urandom_range(32, 25) : $urandom_range(35, 33);
            jumbled = ($urandom_range(99) < 10);
            if ($urandom_range(1))
            begin
                step_max = 3;
                v = $signed($urandom_range(2000)) - 1000;
            end
            else
            begin
                step_max = 1 << 25;
                v = -64'sd2147483648 + $urandom_range(1000);
            end
            while (first_vals.size() < first_goal || second_vals.size() < second_goal)
            begin
                v += $urandom_range(step_max, 1);
                if (jumbled)
                    v = $signed($urandom);
                pick = $urandom_range(2);
                if (pick != 1 && first_vals.size() < first_goal)
                    first_vals = {first_vals, v[31:0]};
                if (pick != 0 && second_vals.size() < second_goal)
                    second_vals = {second_vals, v[31:0]};
            end
            // loads of the two lists interleave at random, with the odd ignored beat
            while (first_vals.size() + second_vals.size() > 0)
            begin
                if ($urandom_range(99) < 4)
                    send_beat(OP_NONE, $urandom);
                if (second_vals.size() == 0 || (first_vals.size() != 0 && $urandom_range(1)))
                    send_beat(ssm_pkg::OP_LOAD_FIRST, first_vals.pop_front());
                else
                    send_beat(ssm_pkg::OP_LOAD_SECOND, second_vals.pop_front());
            end
            // now and then the run is left out and the next lists pile on
            if ($urandom_range(99) >= 8)
                send_beat(ssm_pkg::OP_RUN, $urandom);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_runs();
        test_extreme_values();
        test_difference_and_ignored();
        test_unsorted_lists();
        test_store_full();
        test_random_merges();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("** sorted_set_merge_ops: PASSED **");
        else
            $display("** sorted_set_merge_ops: FAILED **");
        $finish;
    end

endmodule
